>>> hdl/pcfd_pkg.sv
// shared types, register codes and saturation helper for the filtered-derivative pid block
package pcfd_pkg;

   // datapath widths
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SHIFT_W = PROD_W - 16;
   localparam int SUM_W   = 52;

   // unity in q1.16
   localparam logic [16:0] Q_ONE = 17'd65536;

   // register indexes
   localparam logic [2:0] REG_KP        = 3'd0;
   localparam logic [2:0] REG_KI        = 3'd1;
   localparam logic [2:0] REG_KD        = 3'd2;
   localparam logic [2:0] REG_LIMIT     = 3'd3;
   localparam logic [2:0] REG_INV_PER   = 3'd4;
   localparam logic [2:0] REG_ALPHA     = 3'd5;
   localparam logic [2:0] REG_THRESHOLD = 3'd6;
   localparam logic [2:0] REG_MODE      = 3'd7;

   // operating modes
   localparam logic [1:0] MODE_CLASSIC    = 2'd0;
   localparam logic [1:0] MODE_SEPARATION = 2'd1;
   localparam logic [1:0] MODE_TILT       = 2'd2;

   // multiplier operand selection
   typedef enum logic [2:0] {
      MUL_ATT = 3'd0,
      MUL_DER = 3'd1,
      MUL_KI  = 3'd2,
      MUL_FLT = 3'd3,
      MUL_KP  = 3'd4,
      MUL_KD  = 3'd5
   } mul_sel_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic signed [31:0] kp;
      logic signed [31:0] ki;
      logic signed [31:0] kd;
      logic [30:0]        limit;
      logic [30:0]        inv_period;
      logic [16:0]        alpha;
      logic signed [31:0] threshold;
      logic [1:0]         mode;
   } cfg_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        load;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        store_e;
      logic        store_d;
      logic        store_i;
      logic        store_f;
      logic        store_acc;
      logic        store_out;
   } cmd_type;

   // saturate a wide sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(64'sd2147483647);
      lo = SUM_W'(-64'sd2147483648);
      if (x > hi) begin
         return 32'sh7fffffff;
      end else if (x < lo) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage

>>> hdl/pcfd_csr.sv
// apb-style configuration register file
module pcfd_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [4:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output pcfd_pkg::cfg_type cfg
);

   pcfd_pkg::cfg_type cfg_ff;
   pcfd_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            pcfd_pkg::REG_KP:        cfg_in.kp         = csr_pwdata;
            pcfd_pkg::REG_KI:        cfg_in.ki         = csr_pwdata;
            pcfd_pkg::REG_KD:        cfg_in.kd         = csr_pwdata;
            pcfd_pkg::REG_LIMIT:     cfg_in.limit      = csr_pwdata[30:0];
            pcfd_pkg::REG_INV_PER:   cfg_in.inv_period = csr_pwdata[30:0];
            pcfd_pkg::REG_ALPHA:     cfg_in.alpha      = csr_pwdata[16:0];
            pcfd_pkg::REG_THRESHOLD: cfg_in.threshold  = csr_pwdata;
            pcfd_pkg::REG_MODE:      cfg_in.mode       = csr_pwdata[1:0];
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kp         <= '0;
         cfg_ff.ki         <= '0;
         cfg_ff.kd         <= '0;
         cfg_ff.limit      <= 31'h7fffffff;
         cfg_ff.inv_period <= 31'd65536;
         cfg_ff.alpha      <= pcfd_pkg::Q_ONE;
         cfg_ff.threshold  <= 32'sh7fffffff;
         cfg_ff.mode       <= pcfd_pkg::MODE_CLASSIC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (index)
         pcfd_pkg::REG_KP:        csr_prdata = cfg_ff.kp;
         pcfd_pkg::REG_KI:        csr_prdata = cfg_ff.ki;
         pcfd_pkg::REG_KD:        csr_prdata = cfg_ff.kd;
         pcfd_pkg::REG_LIMIT:     csr_prdata = {1'b0, cfg_ff.limit};
         pcfd_pkg::REG_INV_PER:   csr_prdata = {1'b0, cfg_ff.inv_period};
         pcfd_pkg::REG_ALPHA:     csr_prdata = {15'd0, cfg_ff.alpha};
         pcfd_pkg::REG_THRESHOLD: csr_prdata = cfg_ff.threshold;
         pcfd_pkg::REG_MODE:      csr_prdata = {30'd0, cfg_ff.mode};
      endcase
   end

endmodule

>>> hdl/pcfd_ctrl.sv
// step sequencer and handshake control
module pcfd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcfd_pkg::cmd_type cmd
);

   typedef enum logic [8:0] {
      ST_IDLE    = 9'b000000001,
      ST_ERR_MUL = 9'b000000010,
      ST_ERR_SAT = 9'b000000100,
      ST_DER_MUL = 9'b000001000,
      ST_DER_SAT = 9'b000010000,
      ST_INT_ADD = 9'b000100000,
      ST_FLT_ADD = 9'b001000000,
      ST_ACC     = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = pcfd_pkg::MUL_ATT;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_ERR_MUL;
            end
         end
         ST_ERR_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pcfd_pkg::MUL_ATT;
            state_in    = ST_ERR_SAT;
         end
         ST_ERR_SAT: begin
            cmd.store_e = 1'b1;
            state_in    = ST_DER_MUL;
         end
         ST_DER_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pcfd_pkg::MUL_DER;
            state_in    = ST_DER_SAT;
         end
         ST_DER_SAT: begin
            cmd.store_d = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pcfd_pkg::MUL_KI;
            state_in    = ST_INT_ADD;
         end
         ST_INT_ADD: begin
            cmd.store_i = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pcfd_pkg::MUL_FLT;
            state_in    = ST_FLT_ADD;
         end
         ST_FLT_ADD: begin
            cmd.store_f = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = pcfd_pkg::MUL_KP;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.store_acc = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = pcfd_pkg::MUL_KD;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.store_out = 1'b1;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/pcfd_dpath.sv
// datapath: shared multiplier, loop state and result register
module pcfd_dpath (
   input  logic               clock,
   input  logic               reset,
   input  pcfd_pkg::cfg_type  cfg,
   input  pcfd_pkg::cmd_type  cmd,
   input  logic signed [31:0] req_setpoint,
   input  logic signed [31:0] req_measurement,
   input  logic signed [31:0] req_separation_condition,
   input  logic [16:0]        req_attenuation,
   output logic signed [31:0] rsp_drive_value
);

   localparam int MulW   = pcfd_pkg::MUL_W;
   localparam int ProdW  = pcfd_pkg::PROD_W;
   localparam int ShiftW = pcfd_pkg::SHIFT_W;
   localparam int SumW   = pcfd_pkg::SUM_W;

   // latched beat
   logic signed [31:0] sp_ff;
   logic signed [31:0] ms_ff;
   logic signed [31:0] cond_ff;
   logic [16:0]        att_ff;

   // per-item intermediates
   logic signed [31:0]     e_ff;
   logic signed [31:0]     d_ff;
   logic signed [SumW-1:0] acc_ff;
   logic signed [ProdW-1:0] prod_ff;
   logic signed [31:0]     out_ff;

   // loop state
   logic signed [31:0] prev_ff;
   logic signed [31:0] filt_ff;
   logic signed [31:0] integ_ff;

   logic signed [MulW-1:0]  diff;
   logic [16:0]             att_cap;
   logic [16:0]             alpha_cap;
   logic signed [MulW-1:0]  mul_a;
   logic signed [MulW-1:0]  mul_b;
   logic signed [ProdW-1:0] prod;
   logic signed [ShiftW-1:0] prod_sh;
   logic signed [SumW-1:0]  lim;
   logic signed [SumW-1:0]  integ_raw;
   logic signed [31:0]      integ_in;
   logic                    sep_block;

   assign diff      = MulW'(sp_ff) - MulW'(ms_ff);
   assign att_cap   = (att_ff > pcfd_pkg::Q_ONE) ? pcfd_pkg::Q_ONE : att_ff;
   assign alpha_cap = (cfg.alpha > pcfd_pkg::Q_ONE) ? pcfd_pkg::Q_ONE : cfg.alpha;
   // arithmetic shift of the product gives rounding toward minus infinity
   assign prod_sh   = prod_ff[ProdW-1:16];

   // operand selection for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         pcfd_pkg::MUL_ATT: begin
            mul_a = diff;
            mul_b = {16'd0, att_cap};
         end
         pcfd_pkg::MUL_DER: begin
            mul_a = MulW'(e_ff) - MulW'(prev_ff);
            mul_b = {2'b00, cfg.inv_period};
         end
         pcfd_pkg::MUL_KI: begin
            mul_a = MulW'(e_ff);
            mul_b = MulW'(cfg.ki);
         end
         pcfd_pkg::MUL_FLT: begin
            mul_a = MulW'(d_ff) - MulW'(filt_ff);
            mul_b = {16'd0, alpha_cap};
         end
         pcfd_pkg::MUL_KP: begin
            mul_a = MulW'(e_ff);
            mul_b = MulW'(cfg.kp);
         end
         pcfd_pkg::MUL_KD: begin
            mul_a = MulW'(filt_ff);
            mul_b = MulW'(cfg.kd);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // integral update with separation and symmetric clamp
   assign sep_block = (cfg.mode == pcfd_pkg::MODE_SEPARATION) && (cond_ff >= cfg.threshold);
   assign lim       = SumW'({1'b0, cfg.limit});
   always_comb begin
      integ_raw = sep_block ? '0 : (SumW'(integ_ff) + SumW'(prod_sh));
      if (integ_raw > lim) begin
         integ_in = lim[31:0];
      end else if (integ_raw < -lim) begin
         integ_in = 32'(-lim);
      end else begin
         integ_in = integ_raw[31:0];
      end
   end

   // loop state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         filt_ff  <= '0;
         integ_ff <= '0;
      end else begin
         if (cmd.store_d) begin
            prev_ff <= e_ff;
         end
         if (cmd.store_f) begin
            filt_ff <= pcfd_pkg::sat32(SumW'(filt_ff) + SumW'(prod_sh));
         end
         if (cmd.store_i) begin
            integ_ff <= integ_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sp_ff   <= req_setpoint;
         ms_ff   <= req_measurement;
         cond_ff <= req_separation_condition;
         att_ff  <= req_attenuation;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod;
      end
      if (cmd.store_e) begin
         if (cfg.mode == pcfd_pkg::MODE_TILT) begin
            e_ff <= pcfd_pkg::sat32(SumW'(prod_sh));
         end else begin
            e_ff <= pcfd_pkg::sat32(SumW'(diff));
         end
      end
      if (cmd.store_d) begin
         d_ff <= pcfd_pkg::sat32(SumW'(prod_sh));
      end
      if (cmd.store_acc) begin
         acc_ff <= SumW'(prod_sh) + SumW'(integ_ff);
      end
      if (cmd.store_out) begin
         out_ff <= pcfd_pkg::sat32(acc_ff + SumW'(prod_sh));
      end
   end

   assign rsp_drive_value = out_ff;

endmodule

>>> hdl/pid_controller_filtered_derivative_top.sv
// pid controller with low-pass filtered derivative: top level
// an accepted request beat steps through the sequencer states to the response;
// no new beat is taken until idle. The single shared 33x33 multiplier is
// used in six steps of the sequencer, each followed by its own register
// a finished response waits in the output register while the next beat is taken
// reset is synchronous: loop state clears to zero, registers take their defaults
module pid_controller_filtered_derivative_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_setpoint,
   input  logic signed [31:0] req_measurement,
   input  logic signed [31:0] req_separation_condition,
   input  logic [16:0]        req_attenuation,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive_value,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   pcfd_pkg::cfg_type cfg;
   pcfd_pkg::cmd_type cmd;

   // configuration registers
   pcfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer
   pcfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic
   pcfd_dpath u_dpath (
      .clock                    (clock),
      .reset                    (reset),
      .cfg                      (cfg),
      .cmd                      (cmd),
      .req_setpoint             (req_setpoint),
      .req_measurement          (req_measurement),
      .req_separation_condition (req_separation_condition),
      .req_attenuation          (req_attenuation),
      .rsp_drive_value          (rsp_drive_value)
   );

`ifndef ASSERT_OFF
   // an accepted beat makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item was in flight");

   // a new response only appears at the end of a busy item
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised without an item in flight");

   // the output register is never loaded while it still holds an untaken beat
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_drive_value))
      else $error("pending response overwritten");
`endif

endmodule
